// File: rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// Package for the strict base64 decoder: payload types, result codes,
// character classes and the character classifier. Depends on nothing.
package b64d_pkg;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_BAD  = 2'd2;

   localparam logic [6:0] CLS_INVALID = 7'd64;
   localparam logic [6:0] CLS_PAD     = 7'd65;
   localparam logic [6:0] CLS_SPACE   = 7'd66;

   localparam int SLOTS      = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_final;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } slot_type;

   typedef struct packed {
      logic [1:0]           last_idx;
      slot_type [SLOTS-1:0] slots;
   } entry_type;

   function automatic logic [6:0] classify(input logic [7:0] c);
      logic [6:0] v;
      v = CLS_INVALID;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else if (c == 8'h3D) begin
         v = CLS_PAD;
      end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20) begin
         v = CLS_SPACE;
      end
      return v;
   endfunction

endpackage

// File: rtl/b64d_front.sv
`timescale 1ns / 1ps
// Front end of the base64 decoder: classifies each character, keeps the group
// state and forms one queue entry of up to four results. Uses b64d_pkg.
module b64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  b64d_pkg::req_type   req,
   output logic                ent_push,
   output b64d_pkg::entry_type ent
);

   logic [5:0] held_ff [3];
   logic [5:0] held_in [3];
   logic [1:0] gc_ff, gc_in;
   logic       pad_ff, pad_in;
   logic       err_ff, err_in;

   logic [6:0] v;
   logic       active;
   logic [1:0] nd;
   logic       bad1;
   logic       status_en;
   logic       tail_en;
   logic [2:0] n;
   logic [1:0] tail_kind;
   logic [7:0] d [4];

   always_comb begin
      v         = b64d_pkg::classify(req.in_char);
      active    = !err_ff && !pad_ff;
      held_in   = held_ff;
      gc_in     = gc_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      nd        = 2'd0;
      bad1      = 1'b0;
      d[0]      = {held_ff[0], held_ff[1][5:4]};
      d[1]      = {held_ff[1][3:0], held_ff[2][5:2]};
      d[2]      = {held_ff[2][1:0], v[5:0]};
      d[3]      = 8'd0;
      if (active) begin
         if (!v[6]) begin
            if (gc_ff == 2'd3) begin
               nd    = 2'd3;
               gc_in = 2'd0;
            end else begin
               held_in[gc_ff] = v[5:0];
               gc_in          = gc_ff + 2'd1;
            end
         end else if (v == b64d_pkg::CLS_PAD) begin
            if (gc_ff == 2'd2) begin
               nd     = 2'd1;
               pad_in = 1'b1;
            end else if (gc_ff == 2'd3) begin
               nd     = 2'd2;
               pad_in = 1'b1;
            end else begin
               bad1   = 1'b1;
               err_in = 1'b1;
            end
            gc_in = 2'd0;
         end else if (v == b64d_pkg::CLS_INVALID) begin
            bad1   = 1'b1;
            err_in = 1'b1;
         end
      end
      status_en = req.in_final && !err_in;
      tail_kind = bad1 ? b64d_pkg::KIND_BAD
                : ((gc_in != 2'd0) ? b64d_pkg::KIND_BAD : b64d_pkg::KIND_OK);
      tail_en   = bad1 || status_en;
      n         = {1'b0, nd} + {2'b00, tail_en};
      for (int i = 0; i < b64d_pkg::SLOTS; i++) begin
         if (i == int'(nd)) begin
            ent.slots[i].kind = tail_kind;
            ent.slots[i].data = 8'd0;
         end else begin
            ent.slots[i].kind = b64d_pkg::KIND_DATA;
            ent.slots[i].data = d[i];
         end
      end
      ent.last_idx = 2'(n - 3'd1);
      ent_push     = accept && (n != 3'd0);
      if (req.in_final) begin
         held_in = '{default: 6'd0};
         gc_in   = 2'd0;
         pad_in  = 1'b0;
         err_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '{default: 6'd0};
         gc_ff   <= 2'd0;
         pad_ff  <= 1'b0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         gc_ff   <= gc_in;
         pad_ff  <= pad_in;
         err_ff  <= err_in;
      end
   end

endmodule

// File: rtl/b64d_fifo.sv
`timescale 1ns / 1ps
// Short entry queue between the decoder front and back ends.
// Uses b64d_pkg for the entry type and depth.
module b64d_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  b64d_pkg::entry_type wr_data,
   output logic                full,
   input  logic                rd_en,
   output logic                empty,
   output b64d_pkg::entry_type rd_data
);

   b64d_pkg::entry_type             mem_ff [b64d_pkg::FIFO_DEPTH];
   logic [b64d_pkg::PTR_W-1:0] wp_ff, wp_in;
   logic [b64d_pkg::PTR_W-1:0] rp_ff, rp_in;
   logic [b64d_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == b64d_pkg::CNT_W'(b64d_pkg::FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wr_en ? wp_ff + b64d_pkg::PTR_W'(1) : wp_ff;
      rp_in  = rd_en ? rp_ff + b64d_pkg::PTR_W'(1) : rp_ff;
      cnt_in = cnt_ff + b64d_pkg::CNT_W'(wr_en) - b64d_pkg::CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/b64d_back.sv
`timescale 1ns / 1ps
// Base64 decoder back end: walks the head queue entry's slots and presents one
// result per cycle from an output register while popped. Uses b64d_pkg.
module b64d_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  b64d_pkg::entry_type q_data,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output b64d_pkg::rsp_type   rsp_data
);

   logic                  valid_ff, valid_in;
   b64d_pkg::rsp_type     out_ff, out_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  load;
   logic                  at_last;

   always_comb begin
      load     = !q_empty && (!valid_ff || rsp_pop);
      at_last  = (idx_ff == q_data.last_idx);
      q_pop    = load && at_last;
      valid_in = load || (valid_ff && !rsp_pop);
      idx_in   = idx_ff;
      out_in   = out_ff;
      if (load) begin
         out_in.out_kind = q_data.slots[idx_ff].kind;
         out_in.out_byte = q_data.slots[idx_ff].data;
         out_in.out_last = at_last;
         idx_in          = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/base64_strict_decoder.sv
`timescale 1ns / 1ps
// Top level of the strict base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
// Characters enter on the request queue port: a transfer happens when push is
// high and full is low, one character per cycle with in_final on the last
// character of a string. Each character yields zero to four results, held as
// one entry in a four-entry queue between the classifier and the output side.
// Results leave on the response queue port: the oldest result is shown while
// empty is low and is transferred when pop is high. The output side gives one
// result per cycle while pop is high, so sustained input of one character per
// cycle holds as long as results average at most one per character; a final
// character that completes a group gives four results. When the queue and the
// output register are empty, the first result of a character passes through
// the entry queue and then the output register before it is shown. When the
// receiver stalls, the entry queue fills and full rises; nothing is dropped.
// Synchronous reset empties the queue and the output register and returns the
// decoder to the start of a string.
module base64_strict_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  b64d_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output b64d_pkg::rsp_type rsp_data
);

   logic                accept;
   logic                ent_push;
   b64d_pkg::entry_type ent;
   logic                q_empty;
   logic                q_pop;
   b64d_pkg::entry_type q_data;

   assign accept = push && !full;

   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .ent_push (ent_push),
      .ent      (ent)
   );

   b64d_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ent_push),
      .wr_data (ent),
      .full    (full),
      .rd_en   (q_pop),
      .empty   (q_empty),
      .rd_data (q_data)
   );

   b64d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_data  (rsp_data)
   );

endmodule
